// ===== design/latc_pkg.sv =====
package latc_pkg;

  // Fixed field widths of the ports
  localparam int TIME_W       = 48;
  localparam int PORT_VALUE_W = 64;
  localparam int CHAN_W       = 6;
  localparam int TRIG_CH_W    = 7;
  localparam int TRIG_BIT_W   = 6;
  localparam int INDEX_W      = 8;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 64;

  // Defaults for the top-level parameters
  localparam int CHANNELS_DEF     = 64;
  localparam int SAMPLE_DEPTH_DEF = 256;
  localparam int VALUE_BITS_DEF   = 64;

  // Register reset values
  localparam logic [TRIG_CH_W-1:0] TRIG_CHAN_RST         = TRIG_CH_W'(64);
  localparam logic [TIME_W-1:0]    POST_TRIGGER_TIME_RST = TIME_W'(1000);

  typedef enum logic [1:0] {
    ACT_CHANGE = 2'd0,
    ACT_ARM    = 2'd1,
    ACT_POLL   = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TRIG_CHAN         = 3'd0,
    REG_TRIG_POS          = 3'd1,
    REG_EDGE_MODE         = 3'd2,
    REG_MATCH_ENABLE      = 3'd3,
    REG_MATCH_VALUE       = 3'd4,
    REG_POST_TRIGGER_TIME = 3'd5,
    REG_HOLDOFF_TIME      = 3'd6,
    REG_SINGLE_SHOT       = 3'd7
  } cfg_reg_t;

  localparam logic [1:0] EDGE_RISE = 2'd0;
  localparam logic [1:0] EDGE_FALL = 2'd1;

  localparam logic [1:0] KIND_NONE      = 2'd0;
  localparam logic [1:0] KIND_APPEND    = 2'd1;
  localparam logic [1:0] KIND_OVERWRITE = 2'd2;

  // Time add that sticks at all ones
  function automatic logic [TIME_W-1:0] sat_add_time(input logic [TIME_W-1:0] a,
                                                      input logic [TIME_W-1:0] b);
    logic [TIME_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  endfunction

endpackage

// ===== design/latc_if.sv =====
interface latc_item_if
  import latc_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              action;
  logic [CHAN_W-1:0]       channel;
  logic [TIME_W-1:0]       event_time;
  logic [PORT_VALUE_W-1:0] new_value;
  logic [PORT_VALUE_W-1:0] unknown_mask;
  logic [INDEX_W-1:0]      read_index;

  modport source (output valid, action, channel, event_time, new_value, unknown_mask,
                  read_index, input ready);
  modport sink (input valid, action, channel, event_time, new_value, unknown_mask,
                read_index, output ready);
endinterface

interface latc_result_if
  import latc_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic                    frozen;
  logic                    fired;
  logic [TIME_W-1:0]       trigger_stamp;
  logic [1:0]              store_kind;
  logic [TIME_W-1:0]       read_time;
  logic [PORT_VALUE_W-1:0] read_value;
  logic [PORT_VALUE_W-1:0] read_unknown;
  logic                    read_valid;

  modport source (output valid, frozen, fired, trigger_stamp, store_kind, read_time,
                  read_value, read_unknown, read_valid, input ready);
  modport sink (input valid, frozen, fired, trigger_stamp, store_kind, read_time,
                read_value, read_unknown, read_valid, output ready);
endinterface

// ===== design/latc_meta_ram.sv =====
// Per-channel ring pointers; an entry never written reads as empty.
module latc_meta_ram
  import latc_pkg::*;
#(
  parameter int CHANNELS     = CHANNELS_DEF,
  parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       rd_en,
  input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] rd_addr,
  output logic [$clog2(SAMPLE_DEPTH+1)-1:0]          rd_cnt,
  output logic [$clog2(SAMPLE_DEPTH)-1:0]            rd_head,
  input  logic                                       wr_en,
  input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] wr_addr,
  input  logic [$clog2(SAMPLE_DEPTH+1)-1:0]          wr_cnt,
  input  logic [$clog2(SAMPLE_DEPTH)-1:0]            wr_head
);

  localparam int CW = $clog2(SAMPLE_DEPTH + 1);
  localparam int DW = $clog2(SAMPLE_DEPTH);

  logic [CHANNELS-1:0] ent_valid;
  logic [CW+DW-1:0]    mem [CHANNELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
    end else if (wr_en) begin
      ent_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_cnt, wr_head};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (ent_valid[rd_addr]) begin
        {rd_cnt, rd_head} <= mem[rd_addr];
      end else begin
        rd_cnt  <= '0;
        rd_head <= '0;
      end
    end
  end

endmodule

// ===== design/latc_sample_ram.sv =====
// Sample store: {time, value, unknown} per slot, one write and one read port.
module latc_sample_ram
  import latc_pkg::*;
#(
  parameter int ADDR_W = 14,
  parameter int DATA_W = 176
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [1 << ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/logic_analyzer_trigger_capture_unit.sv =====
// Channel   Dir  Transfer when     Payload
// item      in   valid && ready    action, channel, event_time, new_value,
//                                  unknown_mask, read_index
// result    out  valid && ready    frozen, fired, trigger_stamp, store_kind,
//                                  read_time, read_value, read_unknown, read_valid
// cfg       in   cfg_we            cfg_index, cfg_data
//
// One item per cycle sustained while the result is not stalled; the result is offered
// after the item's transfer passes the pointer read at the transfer edge, the sample read and the output load.
// Reset clears the control state and the per-channel valid bits at once; no
// clearing pass, the first item can follow reset directly.
// A stalled result holds the whole pipe; item ready follows result ready
// through the stages, so the block never drops or repeats an item.
module logic_analyzer_trigger_capture_unit
  import latc_pkg::*;
#(
  parameter int CHANNELS     = CHANNELS_DEF,
  parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF,
  parameter int VALUE_BITS   = VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  latc_item_if.sink              item,
  latc_result_if.source          result
);

  localparam int CHW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DW   = $clog2(SAMPLE_DEPTH);
  localparam int CW   = $clog2(SAMPLE_DEPTH + 1);
  localparam int SAW  = CHW + DW;
  localparam int VB   = VALUE_BITS;
  localparam int SDW  = TIME_W + 2 * VB;
  localparam int SUMW = $clog2(2 * SAMPLE_DEPTH + 256) + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [TRIG_CH_W-1:0]  trig_chan;
  logic [TRIG_BIT_W-1:0] trig_pos;
  logic [1:0]            edge_mode;
  logic                  match_enable;
  logic [VB-1:0]         match_value;
  logic [TIME_W-1:0]     post_trigger_time;
  logic [TIME_W-1:0]     holdoff_time;
  logic                  single_shot;

  always_ff @(posedge clk) begin
    if (rst) begin
      trig_chan         <= TRIG_CHAN_RST;
      trig_pos          <= '0;
      edge_mode         <= EDGE_RISE;
      match_enable      <= 1'b0;
      match_value       <= '0;
      post_trigger_time <= POST_TRIGGER_TIME_RST;
      holdoff_time      <= '0;
      single_shot       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_TRIG_CHAN:         trig_chan         <= cfg_data[TRIG_CH_W-1:0];
        REG_TRIG_POS:          trig_pos          <= cfg_data[TRIG_BIT_W-1:0];
        REG_EDGE_MODE:         edge_mode         <= cfg_data[1:0];
        REG_MATCH_ENABLE:      match_enable      <= cfg_data[0];
        REG_MATCH_VALUE:       match_value       <= cfg_data[VB-1:0];
        REG_POST_TRIGGER_TIME: post_trigger_time <= cfg_data[TIME_W-1:0];
        REG_HOLDOFF_TIME:      holdoff_time      <= cfg_data[TIME_W-1:0];
        REG_SINGLE_SHOT:       single_shot       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipe control
  // ---------------------------------------------------------------------------
  logic s1_valid, s2_valid, out_valid;
  logic accept, s1_advance, s2_advance;

  assign s2_advance = s2_valid && (!out_valid || result.ready);
  assign s1_advance = s1_valid && (!s2_valid || s2_advance);
  assign item.ready = !s1_valid || s1_advance;
  assign accept     = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance) begin
        s2_valid <= 1'b1;
      end else if (s2_advance) begin
        s2_valid <= 1'b0;
      end
      if (s2_advance) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  logic [CW-1:0]  meta_rd_cnt;
  logic [DW-1:0]  meta_rd_head;
  logic           meta_we;
  logic [CW-1:0]  meta_wr_cnt;
  logic [DW-1:0]  meta_wr_head;
  logic [SAW-1:0] samp_rd_addr;
  logic [SDW-1:0] samp_rd_data;
  logic           samp_we;
  logic [SAW-1:0] samp_wr_addr;
  logic [SDW-1:0] samp_wr_data;

  logic [CHAN_W-1:0] s2_ch;

  latc_meta_ram #(
    .CHANNELS     (CHANNELS),
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) u_meta (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (item.channel[CHW-1:0]),
    .rd_cnt  (meta_rd_cnt),
    .rd_head (meta_rd_head),
    .wr_en   (meta_we),
    .wr_addr (s2_ch[CHW-1:0]),
    .wr_cnt  (meta_wr_cnt),
    .wr_head (meta_wr_head)
  );

  latc_sample_ram #(
    .ADDR_W (SAW),
    .DATA_W (SDW)
  ) u_samples (
    .clk     (clk),
    .rd_en   (s1_advance),
    .rd_addr (samp_rd_addr),
    .rd_data (samp_rd_data),
    .wr_en   (samp_we),
    .wr_addr (samp_wr_addr),
    .wr_data (samp_wr_data)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: pointers arrive; pick the slot to read
  // ---------------------------------------------------------------------------
  action_t           s1_action;
  logic [CHAN_W-1:0] s1_ch;
  logic [TIME_W-1:0] s1_t;
  logic [VB-1:0]     s1_val;
  logic [VB-1:0]     s1_unk;
  logic [INDEX_W-1:0] s1_k;

  // pointer write that landed in the cycle of the meta read
  logic              mf_valid;
  logic [CHAN_W-1:0] mf_ch;
  logic [CW-1:0]     mf_cnt;
  logic [DW-1:0]     mf_head;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action <= action_t'(item.action);
      s1_ch     <= item.channel;
      s1_t      <= item.event_time;
      s1_val    <= item.new_value[VB-1:0] & ~item.unknown_mask[VB-1:0];
      s1_unk    <= item.unknown_mask[VB-1:0];
      s1_k      <= item.read_index;
      mf_valid  <= meta_we;
      mf_ch     <= s2_ch;
      mf_cnt    <= meta_wr_cnt;
      mf_head   <= meta_wr_head;
    end
  end

  logic [CW-1:0]   s1_cnt;
  logic [DW-1:0]   s1_head;
  logic [DW-1:0]   s1_last;
  logic [DW-1:0]   s1_slot;
  logic [SUMW-1:0] s1_pos;
  logic            s1_read_ok;

  always_comb begin
    // newest pointers: committing item first, then the held write, then RAM
    if (meta_we && s2_ch == s1_ch) begin
      s1_cnt  = meta_wr_cnt;
      s1_head = meta_wr_head;
    end else if (mf_valid && mf_ch == s1_ch) begin
      s1_cnt  = mf_cnt;
      s1_head = mf_head;
    end else begin
      s1_cnt  = meta_rd_cnt;
      s1_head = meta_rd_head;
    end

    s1_last = (s1_head == '0) ? DW'(SAMPLE_DEPTH - 1) : s1_head - 1'b1;

    // oldest retained is at head - count; stays below twice the depth when the index is within the count
    s1_pos = SUMW'(s1_head) + SUMW'(SAMPLE_DEPTH) + SUMW'(s1_k) - SUMW'(s1_cnt);
    if (s1_pos >= SUMW'(SAMPLE_DEPTH)) begin
      s1_pos = s1_pos - SUMW'(SAMPLE_DEPTH);
    end
    s1_read_ok = SUMW'(s1_k) < SUMW'(s1_cnt);

    s1_slot      = (s1_action == ACT_READ) ? DW'(s1_pos) : s1_last;
    samp_rd_addr = {s1_ch[CHW-1:0], s1_slot};
  end

  // ---------------------------------------------------------------------------
  // Stage 2: sample arrives; trigger, store and global state
  // ---------------------------------------------------------------------------
  action_t           s2_action;
  logic [TIME_W-1:0] s2_t;
  logic [VB-1:0]     s2_val;
  logic [VB-1:0]     s2_unk;
  logic [CW-1:0]     s2_cnt;
  logic [DW-1:0]     s2_head;
  logic [SAW-1:0]    s2_addr;
  logic              s2_read_ok;
  logic [TIME_W-1:0] s2_we_cand;

  // sample write that landed in the cycle of the sample read
  logic              sf_valid;
  logic [SAW-1:0]    sf_addr;
  logic [SDW-1:0]    sf_data;

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      s2_action  <= s1_action;
      s2_ch      <= s1_ch;
      s2_t       <= s1_t;
      s2_val     <= s1_val;
      s2_unk     <= s1_unk;
      s2_cnt     <= s1_cnt;
      s2_head    <= s1_head;
      s2_addr    <= samp_rd_addr;
      s2_read_ok <= s1_read_ok;
      s2_we_cand <= sat_add_time(s1_t, post_trigger_time);
      sf_valid   <= samp_we;
      sf_addr    <= samp_wr_addr;
      sf_data    <= samp_wr_data;
    end
  end

  logic              is_frozen, window_set;
  logic [TIME_W-1:0] window_end, last_trigger, earliest_next;
  logic              is_frozen_next, window_set_next;
  logic [TIME_W-1:0] window_end_next, last_trigger_next, earliest_next_next;

  logic [SDW-1:0]    smp;
  logic [TIME_W-1:0] pt;
  logic [VB-1:0]     pv, pu;
  logic [63:0]       pv_w, pu_w, val_w, unk_w;
  logic              ch_ok, freeze_hit, has_prev, same, proceed;
  logic              known, b0, b1, rise, fall, match, fire;
  logic              do_fire, do_over, do_append, rd_hit;
  logic [1:0]        kind;

  always_comb begin
    smp = (sf_valid && sf_addr == s2_addr) ? sf_data : samp_rd_data;
    {pt, pv, pu} = smp;
    pv_w  = 64'(pv);
    pu_w  = 64'(pu);
    val_w = 64'(s2_val);
    unk_w = 64'(s2_unk);

    ch_ok      = {1'b0, s2_ch} < TRIG_CH_W'(CHANNELS);
    freeze_hit = window_set && (s2_t > window_end) && single_shot;
    has_prev   = s2_cnt != '0;
    same       = (pv == s2_val) && (pu == s2_unk);

    // edges only between known levels
    known = !(pu_w[trig_pos] || unk_w[trig_pos]);
    b0    = pv_w[trig_pos];
    b1    = val_w[trig_pos];
    rise  = known && !b0 && b1 && (edge_mode != EDGE_FALL);
    fall  = known && b0 && !b1 && (edge_mode != EDGE_RISE);
    match = !match_enable || (s2_unk == '0 && s2_val == match_value);
    fire  = ({1'b0, s2_ch} == trig_chan)
         && ({1'b0, trig_pos} < TRIG_CH_W'(VALUE_BITS))
         && (s2_t >= earliest_next) && (rise || fall) && match;

    proceed   = (s2_action == ACT_CHANGE) && !is_frozen && !freeze_hit && ch_ok;
    do_fire   = proceed && has_prev && !same && fire;
    do_over   = proceed && has_prev && !same && (pt == s2_t);
    do_append = proceed && (!has_prev || (!same && pt != s2_t));
    rd_hit    = (s2_action == ACT_READ) && ch_ok && s2_read_ok;

    kind = do_over ? KIND_OVERWRITE : (do_append ? KIND_APPEND : KIND_NONE);

    is_frozen_next     = is_frozen;
    window_set_next    = window_set;
    window_end_next    = window_end;
    last_trigger_next  = last_trigger;
    earliest_next_next = earliest_next;
    case (s2_action)
      ACT_CHANGE, ACT_POLL: begin
        if (freeze_hit) begin
          is_frozen_next = 1'b1;
        end
        if (do_fire) begin
          last_trigger_next  = s2_t;
          window_end_next    = s2_we_cand;
          window_set_next    = 1'b1;
          earliest_next_next = sat_add_time(s2_we_cand, holdoff_time);
        end
      end
      ACT_ARM: begin
        is_frozen_next     = 1'b0;
        window_set_next    = 1'b0;
        window_end_next    = '0;
        last_trigger_next  = '0;
        earliest_next_next = s2_t;
      end
      default: ;
    endcase

    // write ports, live only in the commit cycle
    samp_we      = s2_advance && (do_over || do_append);
    samp_wr_addr = do_over ? s2_addr : {s2_ch[CHW-1:0], s2_head};
    samp_wr_data = {s2_t, s2_val, s2_unk};

    meta_we      = s2_advance && do_append;
    meta_wr_head = (s2_head == DW'(SAMPLE_DEPTH - 1)) ? '0 : s2_head + 1'b1;
    meta_wr_cnt  = (s2_cnt == CW'(SAMPLE_DEPTH)) ? s2_cnt : s2_cnt + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_frozen     <= 1'b0;
      window_set    <= 1'b0;
      window_end    <= '0;
      last_trigger  <= '0;
      earliest_next <= '0;
    end else if (s2_advance) begin
      is_frozen     <= is_frozen_next;
      window_set    <= window_set_next;
      window_end    <= window_end_next;
      last_trigger  <= last_trigger_next;
      earliest_next <= earliest_next_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (s2_advance) begin
      result.frozen        <= is_frozen_next;
      result.fired         <= do_fire;
      result.trigger_stamp <= last_trigger_next;
      result.store_kind    <= kind;
      result.read_valid    <= rd_hit;
      result.read_time     <= rd_hit ? pt : '0;
      result.read_value    <= rd_hit ? PORT_VALUE_W'(pv) : '0;
      result.read_unknown  <= rd_hit ? PORT_VALUE_W'(pu) : '0;
    end
  end

  assign result.valid = out_valid;

endmodule
